// ===== hw/rtl/murmur2_hash_stream_top_assert.svh =====
// assertion macros for the murmur2 hash stream block
// used by the controller; needs a clock and a reset signal in scope
`ifndef MURMUR2_HASH_STREAM_TOP_ASSERT_SVH
`define MURMUR2_HASH_STREAM_TOP_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define MH2S_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mh2s: same-cycle check failed");

// next-cycle implication, sampled on the rising clock edge
`define MH2S_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mh2s: next-cycle check failed");

`endif

// ===== hw/rtl/mh2s_pkg.sv =====
// shared constants and types of the murmur2 hash stream block
// no dependencies; imported by the interfaces, datapath, controller and top
`default_nettype none

package mh2s_pkg;

   // hash constants
   localparam logic [31:0] MIX_MULT        = 32'h5bd1_e995;
   localparam int          MIX_SHIFT       = 24;
   localparam int          FIN_SHIFT_A     = 13;
   localparam int          FIN_SHIFT_B     = 15;
   localparam logic [31:0] HASH_SEED_RESET = 32'd5381;
   localparam logic [31:0] MAX_KEY_LENGTH  = 32'd65535;

   // field widths
   localparam int WORD_W  = 32;
   localparam int NBYTE_W = 3;
   localparam int LEN_W   = 16;

   // csr map: register index sits above the byte offset
   localparam int          CSR_ADDR_W    = 3;
   localparam logic [0:0]  REG_HASH_SEED = 1'b0;

   // datapath operations
   typedef enum logic [2:0] {
      DP_NOP,
      DP_MIX1,
      DP_MIX2,
      DP_TAIL,
      DP_FINAL
   } dp_op_type;

   // how the incoming beat is mixed
   typedef enum logic [1:0] {
      KIND_FULL,
      KIND_TAIL,
      KIND_EMPTY
   } kind_type;

   typedef struct packed {
      logic      capture;
      logic      start;
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic     last;
      kind_type kind;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mh2s_ifs.sv =====
// valid/ready channel interfaces for key words and finished hashes
// depends on mh2s_pkg for field widths
`default_nettype none

interface mh2s_req_if
   import mh2s_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic [WORD_W-1:0]    key_word;
   logic [NBYTE_W-1:0]   valid_bytes;
   logic                 last_word;
   logic [LEN_W-1:0]     key_length;

   modport source (output valid, key_word, valid_bytes, last_word, key_length,
                   input ready);
   modport sink   (input valid, key_word, valid_bytes, last_word, key_length,
                   output ready);
endinterface

interface mh2s_rsp_if
   import mh2s_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] hash_value;

   modport source (output valid, hash_value, input ready);
   modport sink   (input valid, hash_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mh2s_datapath.sv =====
// hash datapath: input capture, block mix, tail mix and final mix registers
// depends on mh2s_pkg; driven by mh2s_ctrl through dp_cmd_type
`default_nettype none

module mh2s_datapath
   import mh2s_pkg::*;
(
   input  wire logic               clock,
   input  wire dp_cmd_type         cmd,
   input  wire logic [WORD_W-1:0]  seed,
   input  wire logic [WORD_W-1:0]  key_word,
   input  wire logic [NBYTE_W-1:0] valid_bytes,
   input  wire logic               last_word,
   input  wire logic [LEN_W-1:0]   key_length,
   output dp_stat_type             stat,
   output logic [WORD_W-1:0]       hash_value
);

   logic [WORD_W-1:0] word_ff, word_in;
   logic [WORD_W-1:0] hash_ff, hash_in;
   logic [WORD_W-1:0] kmul_ff, kmul_in;
   logic [WORD_W-1:0] hmul_ff, hmul_in;
   logic [WORD_W-1:0] out_ff, out_in;

   logic [WORD_W-1:0] tail_mask;
   logic [WORD_W-1:0] sat_len;
   logic [WORD_W-1:0] kmix;
   logic [WORD_W-1:0] fmix;

   // classify the incoming beat
   always_comb begin
      stat.last = last_word;
      if (!last_word || valid_bytes >= NBYTE_W'(4)) begin
         stat.kind = KIND_FULL;
      end else if (valid_bytes == '0) begin
         stat.kind = KIND_EMPTY;
      end else begin
         stat.kind = KIND_TAIL;
      end
   end

   // keep only the valid tail bytes
   always_comb begin
      unique case (valid_bytes)
         NBYTE_W'(1): tail_mask = 32'h0000_00ff;
         NBYTE_W'(2): tail_mask = 32'h0000_ffff;
         NBYTE_W'(3): tail_mask = 32'h00ff_ffff;
         default:     tail_mask = 32'hffff_ffff;
      endcase
   end

   // starting value: seed xor clamped length
   assign sat_len = (WORD_W'(key_length) > MAX_KEY_LENGTH) ? MAX_KEY_LENGTH
                                                          : WORD_W'(key_length);

   assign kmix = kmul_ff ^ (kmul_ff >> MIX_SHIFT);
   assign fmix = hash_ff ^ (hash_ff >> FIN_SHIFT_A);

   // next values of the datapath registers
   always_comb begin
      word_in = word_ff;
      hash_in = hash_ff;
      kmul_in = kmul_ff;
      hmul_in = hmul_ff;
      out_in  = out_ff;
      if (cmd.capture) begin
         word_in = (stat.kind == KIND_TAIL) ? (key_word & tail_mask) : key_word;
      end
      if (cmd.start) begin
         hash_in = seed ^ sat_len;
      end
      unique case (cmd.op)
         DP_MIX1: begin
            kmul_in = WORD_W'(word_ff * MIX_MULT);
            hmul_in = WORD_W'(hash_ff * MIX_MULT);
         end
         DP_MIX2: begin
            hash_in = hmul_ff ^ WORD_W'(kmix * MIX_MULT);
         end
         DP_TAIL: begin
            hash_in = WORD_W'((hash_ff ^ word_ff) * MIX_MULT);
         end
         DP_FINAL: begin
            out_in = WORD_W'(fmix * MIX_MULT);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      hash_ff <= hash_in;
      kmul_ff <= kmul_in;
      hmul_ff <= hmul_in;
      out_ff  <= out_in;
   end

   // last shift of the final mix sits after the output register
   assign hash_value = out_ff ^ (out_ff >> FIN_SHIFT_B);

endmodule

`default_nettype wire

// ===== hw/rtl/mh2s_ctrl.sv =====
// controller state machine: handshakes, key tracking and datapath sequencing
// depends on mh2s_pkg and murmur2_hash_stream_top_assert.svh
`default_nettype none

`include "murmur2_hash_stream_top_assert.svh"

module mh2s_ctrl
   import mh2s_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX1,
      ST_MIX2,
      ST_TAIL,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   state_type decode_state;
   logic      inside_key_ff, inside_key_in;
   logic      last_ff, last_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   // a new beat is taken when idle or while the previous word finishes
   assign req_ready = (state_ff == ST_IDLE) || (state_ff == ST_MIX2 && !last_ff);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // first step for an accepted beat
   always_comb begin
      unique case (stat.kind)
         KIND_TAIL:  decode_state = ST_TAIL;
         KIND_EMPTY: decode_state = ST_FIN;
         default:    decode_state = ST_MIX1;
      endcase
   end

   // next state and datapath command
   always_comb begin
      state_in    = state_ff;
      cmd.capture = accept;
      cmd.start   = accept && !inside_key_ff;
      cmd.op      = DP_NOP;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = decode_state;
            end
         end
         ST_MIX1: begin
            cmd.op   = DP_MIX1;
            state_in = ST_MIX2;
         end
         ST_MIX2: begin
            cmd.op = DP_MIX2;
            priority if (last_ff) begin
               state_in = ST_FIN;
            end else if (accept) begin
               state_in = decode_state;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_TAIL: begin
            cmd.op   = DP_TAIL;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.op   = DP_FINAL;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // key tracking and result valid
   always_comb begin
      inside_key_in = accept ? !stat.last : inside_key_ff;
      last_in       = accept ? stat.last : last_ff;
      priority if (cmd.op == DP_FINAL) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         inside_key_ff <= 1'b0;
         last_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         inside_key_ff <= inside_key_in;
         last_ff       <= last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // checks
   `MH2S_ASSERT_NEXT(a_full_goes_mix, accept && stat.kind == KIND_FULL, state_ff == ST_MIX1)
   `MH2S_ASSERT_NOW(a_final_out_free, cmd.op == DP_FINAL, !rsp_valid_ff || rsp_ready)
   `MH2S_ASSERT_NOW(a_fin_key_closed, state_ff == ST_FIN, !inside_key_ff)
   `MH2S_ASSERT_NOW(a_mix2_in_key, state_ff == ST_MIX2 && accept, inside_key_ff && !cmd.start)

endmodule

`default_nettype wire

// ===== hw/rtl/murmur2_hash_stream_top.sv =====
// murmur2 hash stream: streaming 32-bit murmurhash2 over little-endian words
//
// req channel: one beat per key word (key_word, valid_bytes, last_word,
//   key_length); key_length is sampled on the first beat of a key and the
//   hash starts as hash_seed xor that length
// rsp channel: one beat per key, carrying hash_value, after its last word
// csr port: apb-style, register hash_seed at byte address 0, reset 5381;
//   read only at the start of a key
// block mix: a word that is not last passes the two registered multiplier
//   stages of the block mix, MIX1 and MIX2; the next beat is taken in the
//   second of them
// last word: a full word then passes the two multiply stages of the block mix,
//   1 to 3 tail bytes the one tail stage and an empty tail neither; the
//   final mix stage then registers the result and sets rsp valid, and
//   waits while the output register is still full
// reset: synchronous, active high; clears the controller, returns the seed
//   register to 5381, drops rsp valid and waits for the first word of a key
// stall: the finished hash sits in an output register; while it waits the
//   next key is taken, and a second hash holds in the final step until the
//   output register is free
// depends on mh2s_pkg, mh2s_ifs, mh2s_ctrl and mh2s_datapath
`default_nettype none

module murmur2_hash_stream_top
   import mh2s_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   mh2s_req_if.sink                   req_bus,
   mh2s_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   logic [WORD_W-1:0] seed_ff, seed_in;
   logic              csr_write;
   logic              seed_sel;
   dp_cmd_type        cmd;
   dp_stat_type       stat;

   // seed register
   assign csr_pready = 1'b1;
   assign seed_sel   = (csr_paddr[CSR_ADDR_W-1:2] == REG_HASH_SEED);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign seed_in    = (csr_write && seed_sel) ? csr_pwdata : seed_ff;
   assign csr_prdata = seed_sel ? seed_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= HASH_SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   mh2s_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mh2s_datapath u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .seed        (seed_ff),
      .key_word    (req_bus.key_word),
      .valid_bytes (req_bus.valid_bytes),
      .last_word   (req_bus.last_word),
      .key_length  (req_bus.key_length),
      .stat        (stat),
      .hash_value  (rsp_bus.hash_value)
   );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for murmur2_hash_stream_top: key words in, one hash per key out
// depends on mh2s_pkg, mh2s_ifs and the rtl of the block

module tb;
   import mh2s_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 10;
   localparam int LONG_STALL     = 400;
   localparam int NUM_PHASES     = 6;
   localparam int PHASE_WORDS    = 155;
   localparam int NUM_ROWS       = 18;
   localparam logic [CSR_ADDR_W-1:0] SEED_ADDR = {REG_HASH_SEED, 2'b00};

   typedef enum logic [1:0] {
      PACE_RX_SLOW,
      PACE_TX_SLOW,
      PACE_FULL
   } pace_type;

   typedef struct packed {
      bit                 set_seed;
      logic [31:0]        seed;
      logic [WORD_W-1:0]  key_word;
      logic [NBYTE_W-1:0] valid_bytes;
      bit                 last_word;
      logic [LEN_W-1:0]   key_length;
      bit                 typed;
      logic [31:0]        hash;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   mh2s_req_if req_bus ();
   mh2s_rsp_if rsp_bus ();

   murmur2_hash_stream_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // hash model state
   logic [31:0] seed_model;
   logic [31:0] run_hash;
   bit          in_key;
   logic [31:0] hash_q [$];
   int          fails = 0;
   pace_type    pace = PACE_RX_SLOW;

   // directed rows: typed hashes only where seed 0, length 0 and no data leave zero
   stim_row_type directed_rows [NUM_ROWS] = '{
      '{1'b0, 32'h0, 32'h6463_6261, 3'd4, 1'b1, 16'd4, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'h0000_0000, 3'd7, 1'b0, 16'hFFFF, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'hFFFF_FFFF, 3'd0, 1'b0, 16'h0000, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'h8000_0001, 3'd5, 1'b1, 16'h1234, 1'b0, 32'h0},
      '{1'b1, 32'h0, 32'hFFFF_FFFF, 3'd0, 1'b1, 16'd0, 1'b1, 32'h0},
      '{1'b0, 32'h0, 32'hFFFF_FF00, 3'd1, 1'b1, 16'd0, 1'b1, 32'h0},
      '{1'b0, 32'h0, 32'hFFFF_0000, 3'd2, 1'b1, 16'd0, 1'b1, 32'h0},
      '{1'b0, 32'h0, 32'hFF00_0000, 3'd3, 1'b1, 16'd0, 1'b1, 32'h0},
      '{1'b0, 32'h0, 32'hDEAD_BEEF, 3'd4, 1'b0, 16'd7, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'h00C0_FFEE, 3'd3, 1'b1, 16'd7, 1'b0, 32'h0},
      '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4, 1'b1, 16'hFFFF, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'h0000_0000, 3'd6, 1'b1, 16'd0, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'h0000_0001, 3'd7, 1'b1, 16'd2, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'h1234_5678, 3'd0, 1'b0, 16'd100, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'h9ABC_DEF0, 3'd2, 1'b1, 16'd100, 1'b0, 32'h0},
      '{1'b1, HASH_SEED_RESET, 32'h5555_AAAA, 3'd1, 1'b0, 16'd9, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'hAAAA_5555, 3'd0, 1'b0, 16'd3, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'h0F0F_F0F0, 3'd1, 1'b1, 16'd5, 1'b0, 32'h0}
   };

   function automatic int tx_idle_pct(pace_type p);
      return (p == PACE_RX_SLOW) ? 33 : (p == PACE_TX_SLOW) ? 82 : 0;
   endfunction

   function automatic int rx_idle_pct(pace_type p);
      return (p == PACE_RX_SLOW) ? 82 : (p == PACE_TX_SLOW) ? 33 : 0;
   endfunction

   // one block mix step of the hash
   function automatic logic [31:0] mix_word(logic [31:0] h, logic [31:0] w);
      logic [31:0] k;
      k = w * MIX_MULT;
      k = k ^ (k >> MIX_SHIFT);
      k = k * MIX_MULT;
      return (h * MIX_MULT) ^ k;
   endfunction

   // folds one accepted word into the running hash; returns 1 with the finished hash
   function automatic bit absorb_word(input logic [31:0] kw, input logic [2:0] nb,
                                      input bit last, input logic [15:0] len,
                                      output logic [31:0] hash);
      logic [31:0] h;
      logic [2:0]  n;
      logic [31:0] mask;
      if (!in_key) begin
         run_hash = seed_model ^ {16'h0, len};
         in_key = 1'b1;
      end
      h = run_hash;
      hash = h;
      if (!last) begin
         run_hash = mix_word(h, kw);
         return 1'b0;
      end
      n = (nb > 3'd4) ? 3'd4 : nb;
      if (n == 3'd4) begin
         h = mix_word(h, kw);
      end else if (n != 3'd0) begin
         mask = (32'h1 << (n * 8)) - 32'h1;
         h = (h ^ (kw & mask)) * MIX_MULT;
      end
      h = h ^ (h >> FIN_SHIFT_A);
      h = h * MIX_MULT;
      h = h ^ (h >> FIN_SHIFT_B);
      run_hash = h;
      in_key = 1'b0;
      hash = h;
      return 1'b1;
   endfunction

   // offer one word beat, with random gaps before it
   task automatic put_word(input logic [31:0] kw, input logic [2:0] nb, input bit last,
                           input logic [15:0] len, input bit typed,
                           input logic [31:0] typed_hash);
      logic [31:0] h;
      while ($urandom_range(99) < tx_idle_pct(pace)) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.key_word    <= kw;
      req_bus.valid_bytes <= nb;
      req_bus.last_word   <= last;
      req_bus.key_length  <= len;
      do @(posedge clock); while (!req_bus.ready);
      if (absorb_word(kw, nb, last, len, h))
         hash_q.push_back(typed ? typed_hash : h);
   endtask

   // read the seed register back and compare
   task automatic check_seed_reg(input logic [31:0] want);
      logic [31:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= SEED_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== want) begin
         $display("%0t: seed readback mismatch, expected %h got %h", $time, want, got);
         fails++;
      end
   endtask

   // let all pending hashes out, then write the seed while the block is idle
   task automatic write_seed(input logic [31:0] value);
      req_bus.valid <= 1'b0;
      while (hash_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SEED_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // the readback setup follows directly and ends the write beat
      seed_model = value;
      check_seed_reg(value);
   endtask

   // one random key: mostly short, now and then long, length usually consistent
   task automatic send_random_key(inout int sent);
      int          nwords;
      logic [2:0]  nb;
      logic [15:0] len;
      nwords = ($urandom_range(9) == 0) ? $urandom_range(24, 8) : $urandom_range(5, 1);
      nb = ($urandom_range(7) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 0));
      len = ($urandom_range(9) == 0) ? 16'($urandom)
                                     : 16'(4 * (nwords - 1) + ((nb > 3'd4) ? 4 : nb));
      for (int i = 0; i < nwords; i++) begin
         put_word($urandom, (i == nwords - 1) ? nb : 3'($urandom_range(7)),
                  i == nwords - 1, (i == 0) ? len : 16'($urandom), 1'b0, 32'h0);
      end
      sent += nwords;
   endtask

   // result receiver, with one long hold-off once full-rate traffic starts
   int stall_count = 0;
   bit stall_done  = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (pace == PACE_FULL && !stall_done) begin
         rsp_bus.ready <= 1'b0;
         stall_count <= stall_count + 1;
         if (stall_count == LONG_STALL - 1)
            stall_done <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct(pace));
      end
   end

   // result check and watchdog
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (hash_q.size() == 0) begin
               $display("%0t: unexpected hash beat, expected none got %h", $time,
                        rsp_bus.hash_value);
               fails++;
            end else if (rsp_bus.hash_value !== hash_q[0]) begin
               $display("%0t: hash mismatch, expected %h got %h", $time, hash_q[0],
                        rsp_bus.hash_value);
               fails++;
               void'(hash_q.pop_front());
            end else begin
               void'(hash_q.pop_front());
            end
         end
         if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      int sent;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.key_word    <= '0;
      req_bus.valid_bytes <= '0;
      req_bus.last_word   <= 1'b0;
      req_bus.key_length  <= '0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      seed_model = HASH_SEED_RESET;
      run_hash   = '0;
      in_key     = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_seed_reg(HASH_SEED_RESET);

      // directed table
      foreach (directed_rows[r]) begin
         if (directed_rows[r].set_seed)
            write_seed(directed_rows[r].seed);
         put_word(directed_rows[r].key_word, directed_rows[r].valid_bytes,
                  directed_rows[r].last_word, directed_rows[r].key_length,
                  directed_rows[r].typed, directed_rows[r].hash);
      end

      // random phases: two seeds per pacing mode
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: write_seed(32'h0000_0000);
            1: write_seed(32'hFFFF_FFFF);
            default: write_seed($urandom);
         endcase
         pace <= pace_type'(p / 2);
         sent = 0;
         while (sent < PHASE_WORDS)
            send_random_key(sent);
      end

      req_bus.valid <= 1'b0;
      while (hash_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fails == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
